// File: sv/tcc_pkg.sv
// Shared types and constants for the thermostat clock controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcc_pkg;

   // Command codes carried in an input word
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_MODE   = 3'd1,
      CMD_UP     = 3'd2,
      CMD_DOWN   = 3'd3,
      CMD_ONOFF  = 3'd4,
      CMD_SAMPLE = 3'd5
   } cmd_type;

   // Operating modes
   typedef enum logic [1:0] {
      MODE_RUN      = 2'd0,
      MODE_SET_HOUR = 2'd1,
      MODE_SET_MIN  = 2'd2,
      MODE_SET_TEMP = 2'd3
   } mode_type;

   // Registered input word, handed from the input stage to the state units
   typedef struct packed {
      logic       fire;
      cmd_type    cmd;
      logic [7:0] temperature;
   } step_type;

   localparam logic [7:0] TPS_RESET  = 8'd20;
   localparam logic [5:0] SEC_MAX    = 6'd59;
   localparam logic [5:0] MIN_MAX    = 6'd59;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [4:0] HOUR_RESET = 5'd12;
   localparam logic [6:0] SET_MAX    = 7'd99;
   localparam logic [6:0] SET_MIN    = 7'd1;

endpackage

`default_nettype wire

// File: sv/tcc_clock.sv
// Time-of-day counters: sub-second ticks, seconds, minutes, hours.
// Depends on tcc_pkg; set-hour and set-minute keys come in via the mode.
`default_nettype none

module tcc_clock
   import tcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire step_type   step,
   input  wire mode_type   mode,
   input  wire logic [7:0] ticks_per_second,
   output logic      [4:0] hours,
   output logic      [5:0] minutes,
   output logic      [5:0] seconds
);

   logic [7:0] tick_ff, tick_in;
   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [4:0] hour_ff, hour_in;
   logic [7:0] tick_inc;
   logic       sec_carry, min_carry, hour_carry;

   // Carry chain for a tick word
   assign tick_inc   = tick_ff + 8'd1;
   assign sec_carry  = (tick_inc >= ticks_per_second);
   assign min_carry  = sec_carry && (sec_ff >= SEC_MAX);
   assign hour_carry = min_carry && (min_ff >= MIN_MAX);

   // Next counter values
   always_comb begin
      tick_in = tick_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      if (step.fire) begin
         unique case (step.cmd)
            CMD_TICK: begin
               tick_in = sec_carry ? 8'd0 : tick_inc;
               if (sec_carry) begin
                  sec_in = min_carry ? 6'd0 : sec_ff + 6'd1;
               end
               if (min_carry) begin
                  min_in = hour_carry ? 6'd0 : min_ff + 6'd1;
               end
               if (hour_carry) begin
                  hour_in = (hour_ff >= HOUR_MAX) ? 5'd0 : hour_ff + 5'd1;
               end
            end
            CMD_UP: begin
               if (mode == MODE_SET_HOUR) begin
                  hour_in = (hour_ff >= HOUR_MAX) ? HOUR_MAX : hour_ff + 5'd1;
               end else if (mode == MODE_SET_MIN) begin
                  min_in = (min_ff >= MIN_MAX) ? MIN_MAX : min_ff + 6'd1;
               end
            end
            CMD_DOWN: begin
               if (mode == MODE_SET_HOUR && hour_ff != 5'd0) begin
                  hour_in = hour_ff - 5'd1;
               end else if (mode == MODE_SET_MIN && min_ff != 6'd0) begin
                  min_in = min_ff - 6'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= 8'd0;
         sec_ff  <= 6'd0;
         min_ff  <= 6'd0;
         hour_ff <= HOUR_RESET;
      end else begin
         tick_ff <= tick_in;
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
      end
   end

   assign hours   = hour_ff;
   assign minutes = min_ff;
   assign seconds = sec_ff;

endmodule

`default_nettype wire

// File: sv/tcc_ctrl.sv
// Mode, setpoint, enable and hysteresis cooling control.
// Depends on tcc_pkg; feeds the mode to the clock counters.
`default_nettype none

module tcc_ctrl
   import tcc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step,
   output mode_type      mode,
   output logic    [6:0] setpoint,
   output logic          enabled,
   output logic          cooling_on
);

   mode_type   mode_ff, mode_in;
   logic [6:0] set_ff, set_in;
   logic       en_ff, en_in;
   logic       cool_ff, cool_in;
   logic       temp_high, temp_low;

   // Hysteresis thresholds: on at setpoint+1 or above, off below setpoint
   assign temp_high = ({1'b0, step.temperature} >= ({2'b00, set_ff} + 9'd1));
   assign temp_low  = (step.temperature < {1'b0, set_ff});

   always_comb begin
      mode_in = mode_ff;
      set_in  = set_ff;
      en_in   = en_ff;
      cool_in = cool_ff;
      if (step.fire) begin
         unique case (step.cmd)
            CMD_MODE: mode_in = mode_type'(mode_ff + 2'd1);
            CMD_UP: begin
               if (mode_ff == MODE_SET_TEMP) begin
                  set_in = (set_ff >= SET_MAX) ? SET_MAX : set_ff + 7'd1;
               end
            end
            CMD_DOWN: begin
               if (mode_ff == MODE_SET_TEMP) begin
                  set_in = (set_ff <= 7'd2) ? SET_MIN : set_ff - 7'd1;
               end
            end
            CMD_ONOFF: begin
               en_in = !en_ff;
               if (en_ff) begin
                  cool_in = 1'b0;
               end
            end
            CMD_SAMPLE: begin
               if (!en_ff) begin
                  cool_in = 1'b0;
               end else if (temp_high) begin
                  cool_in = 1'b1;
               end else if (temp_low) begin
                  cool_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RUN;
         set_ff  <= 7'd0;
         en_ff   <= 1'b0;
         cool_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         set_ff  <= set_in;
         en_ff   <= en_in;
         cool_ff <= cool_in;
      end
   end

   assign mode       = mode_ff;
   assign setpoint   = set_ff;
   assign enabled    = en_ff;
   assign cooling_on = cool_ff & en_ff;

endmodule

`default_nettype wire

// File: sv/thermostat_clock_controller_top.sv
// Thermostat clock controller: input stage, state units and result handshake.
// Depends on tcc_pkg, tcc_clock and tcc_ctrl.
//
// Usage:
//   req channel: one word per tick, key press or temperature sample
//   (req_cmd, req_temperature), taken at an edge with req_valid high and
//   req_stall low.
//   rsp channel: one word per request, a snapshot of clock, mode, setpoint,
//   enable and cooling after that request, taken when rsp_valid is high and
//   rsp_stall low.
//   csr channel: writes ticks_per_second; csr_ready is always high. Write
//   only while no request is in flight.
// Path: a request taken into the input register moves into the state
//   registers, which double as the result register, once the result slot frees.
// Throughput: one word per cycle while no result waits under rsp_stall.
// Stall: while a result waits under rsp_stall, one more request is held in
//   the input register and req_stall rises.
// Reset: clock 12:00:00, run mode, setpoint 0, control off, cooling off,
//   ticks_per_second 20, both channels empty.
`default_nettype none

module thermostat_clock_controller_top
   import tcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_cmd,
   input  wire logic [7:0] req_temperature,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [4:0] rsp_hours,
   output logic      [5:0] rsp_minutes,
   output logic      [5:0] rsp_seconds,
   output logic      [1:0] rsp_mode,
   output logic      [6:0] rsp_setpoint,
   output logic            rsp_enabled,
   output logic            rsp_cooling_on,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data
);

   logic       in_valid_ff;
   cmd_type    in_cmd_ff;
   logic [7:0] in_temp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] tps_ff;
   logic       advance;
   step_type   step;
   mode_type   mode;

   // Result slot frees when empty or taken this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_cmd_ff  <= cmd_type'(req_cmd);
         in_temp_ff <= req_temperature;
      end
   end

   // Word handed to the state units
   assign step.fire        = in_valid_ff && advance;
   assign step.cmd         = in_cmd_ff;
   assign step.temperature = in_temp_ff;

   // Result valid flag
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Ticks-per-second register
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_valid && csr_ready) begin
         tps_ff <= csr_data;
      end
   end

   tcc_clock u_clock (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .mode             (mode),
      .ticks_per_second (tps_ff),
      .hours            (rsp_hours),
      .minutes          (rsp_minutes),
      .seconds          (rsp_seconds)
   );

   tcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .mode       (mode),
      .setpoint   (rsp_setpoint),
      .enabled    (rsp_enabled),
      .cooling_on (rsp_cooling_on)
   );

   assign rsp_mode  = mode;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // Result fields stay inside their ranges
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_hours <= HOUR_MAX && rsp_minutes <= MIN_MAX &&
      rsp_seconds <= SEC_MAX && rsp_setpoint <= SET_MAX)
      else $error("result field out of range");

   // Cooling is never driven while control is off
   a_cool_en: assert property (@(posedge clock) disable iff (reset)
      rsp_cooling_on |-> rsp_enabled)
      else $error("cooling on while disabled");

   // A word leaving the input register always produces a result
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      step.fire |=> rsp_valid)
      else $error("result lost after input word fired");

   // Held result does not move while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hours) && $stable(rsp_minutes) &&
      $stable(rsp_seconds) && $stable(rsp_setpoint) && $stable(rsp_cooling_on))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
